// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Each macro expands to a labeled concurrent assertion in simulation and
// to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: rtl/core/rsfd_pkg.sv
// ----------------------------------------------------------------------------
// rsfd_pkg
// Shared constants and types of the robot status frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsfd_pkg;

  localparam int FRAME_LEN = 8;
  localparam int CNT_W     = $clog2(FRAME_LEN);
  localparam int BODY_LEN  = FRAME_LEN - 1;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

  localparam logic [7:0] HEADER_BYTE  = 8'h52;
  localparam logic [7:0] TRAILER_BYTE = 8'h45;

  // floor(x / 5) for x below 2730 equals (x * 1639) >> 13.
  localparam int MIX_W       = 11;
  localparam int SPEED_SHIFT = 13;
  localparam logic [MIX_W-1:0] SPEED_RECIP = MIX_W'(1639);

  typedef logic [7:0] rx_word_t;

  // Entry k holds the word that arrived k+1 words before the newest one.
  typedef rx_word_t [BODY_LEN-1:0] frame_body_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  speed;
    logic [15:0] position;
    logic [9:0]  steering;
    logic [4:0]  line_left;
    logic [4:0]  line_right;
    logic [2:0]  limit_switches;
  } frame_fields_t;

endpackage

`default_nettype wire

// File: rtl/core/rsfd_byte_cell.sv
// ----------------------------------------------------------------------------
// rsfd_byte_cell
// One stage of the frame shift line: holds one word and passes it on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsfd_byte_cell (
  input  wire logic              clk,
  input  wire logic              shift,
  input  wire rsfd_pkg::rx_word_t d,
  output rsfd_pkg::rx_word_t     q
);
  import rsfd_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rsfd_frame_eval.sv
// ----------------------------------------------------------------------------
// rsfd_frame_eval
// Checks a complete frame and unpacks its readings, including the new
// smoothed speed floor((2*new + 3*old) / 5).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsfd_frame_eval (
  input  wire rsfd_pkg::frame_body_t body,
  input  wire rsfd_pkg::rx_word_t    last_word,
  input  wire logic [7:0]            old_speed,
  output rsfd_pkg::frame_fields_t    fields
);
  import rsfd_pkg::*;

  rx_word_t                  w [FRAME_LEN];
  logic [MIX_W-1:0]          mix;
  logic [2*MIX_W-1:0]        prod;

  // Frame word k sits in body entry BODY_LEN-1-k; the last word is live.
  always_comb begin
    for (int k = 0; k < BODY_LEN; k++) begin
      w[k] = body[BODY_LEN-1-k];
    end
    w[FRAME_LEN-1] = last_word;
  end

  always_comb begin
    mix  = (MIX_W'(w[1]) << 1) + (MIX_W'(old_speed) << 1) + MIX_W'(old_speed);
    prod = {{MIX_W{1'b0}}, mix} * {{MIX_W{1'b0}}, SPEED_RECIP};

    fields.ok             = (w[0] == HEADER_BYTE) && (w[FRAME_LEN-1] == TRAILER_BYTE);
    fields.speed          = prod[SPEED_SHIFT +: 8];
    fields.position       = {w[2], w[3]};
    fields.steering       = {w[4], w[5][7:6]};
    fields.line_left      = w[5][5:1];
    fields.line_right     = w[6][7:3];
    fields.limit_switches = w[6][2:0];
  end

endmodule

`default_nettype wire

// File: rtl/core/robot_status_frame_decoder.sv
// ----------------------------------------------------------------------------
// robot_status_frame_decoder
// Collects serial words into eight-word status frames and reports the
// checked, held robot readings once per frame.
// ----------------------------------------------------------------------------
// The decoder takes one received word per clock on the rx channel and emits
// one result word after every eighth accepted word, counting from reset or
// from the previous frame; there is no header resynchronization. Incoming
// words move through a row of seven word cells, so when the eighth word
// arrives the whole frame is visible at once and is checked in the same
// cycle: it passes only if the first word is 'R' and the last is 'E'. A
// passing frame updates the held readings, with the speed smoothed as
// floor((2*new + 3*old) / 5); a failing frame keeps them. The result appears
// in the cycle after the eighth word and carries frame_ok plus the held
// readings, which sit in registers that feed the result ports directly.
// Throughput is one word per cycle. While a result waits on frame_stall,
// the first seven words of the next frame are still taken; only the word
// that would finish that frame is held off with rx_stall until the waiting
// result is taken, since the held reading registers double as the result
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module robot_status_frame_decoder (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rx_valid,
  output logic                     rx_stall,
  input  wire rsfd_pkg::rx_word_t  rx_byte,
  output logic                     frame_valid,
  input  wire logic                frame_stall,
  output logic                     frame_ok,
  output logic [7:0]               speed,
  output logic [15:0]              position,
  output logic [9:0]               steering,
  output logic [4:0]               line_left,
  output logic [4:0]               line_right,
  output logic [2:0]               limit_switches
);
  import rsfd_pkg::*;

  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  frame_body_t      body;
  frame_fields_t    fields;
  logic             rx_fire;
  logic             frame_done;
  logic             frame_valid_next;

  // The word that completes a frame must wait while an earlier result is
  // still stalled, since that result lives in the held reading registers.
  assign rx_stall   = frame_valid && frame_stall && (byte_count == LAST_IDX);
  assign rx_fire    = rx_valid && !rx_stall;
  assign frame_done = rx_fire && (byte_count == LAST_IDX);

  // Shift line of word cells: cell 0 takes the newest word.
  for (genvar i = 0; i < BODY_LEN; i++) begin : g_cell
    rsfd_byte_cell u_cell (
      .clk   (clk),
      .shift (rx_fire),
      .d     ((i == 0) ? rx_byte : body[(i == 0) ? 0 : i - 1]),
      .q     (body[i])
    );
  end

  rsfd_frame_eval u_eval (
    .body      (body),
    .last_word (rx_byte),
    .old_speed (speed),
    .fields    (fields)
  );

  always_comb begin
    byte_count_next = byte_count;
    if (rx_fire) begin
      byte_count_next = (byte_count == LAST_IDX) ? '0 : byte_count + 1'b1;
    end
    frame_valid_next = frame_done || (frame_valid && frame_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      frame_valid <= 1'b0;
    end else begin
      byte_count  <= byte_count_next;
      frame_valid <= frame_valid_next;
    end
  end

  // Held readings change only on a passing frame and drive the result ports.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed          <= '0;
      position       <= '0;
      steering       <= '0;
      line_left      <= '0;
      line_right     <= '0;
      limit_switches <= '0;
    end else if (frame_done && fields.ok) begin
      speed          <= fields.speed;
      position       <= fields.position;
      steering       <= fields.steering;
      line_left      <= fields.line_left;
      line_right     <= fields.line_right;
      limit_switches <= fields.limit_switches;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      frame_ok <= fields.ok;
    end
  end

  // A finished frame restarts the count and raises a result.
  `ASSERT_CLK(a_frame_restarts, clk, rst, frame_done |=> (byte_count == '0 && frame_valid), "frame end did not restart count or raise result")

  // A new result is only ever caused by the word that finished a frame.
  `ASSERT_CLK(a_result_source, clk, rst, (frame_valid && !$past(frame_valid && frame_stall)) |-> ($past(frame_done)), "result raised without a finished frame")

  // A rejected frame leaves the smoothed speed untouched.
  `ASSERT_CLK(a_reject_holds, clk, rst, ($past(frame_done) && !frame_ok) |-> $stable(speed), "rejected frame changed held speed")

  // A waiting result is never overwritten by the next finished frame.
  `ASSERT_NEVER(a_no_overrun, clk, rst, frame_valid && frame_stall && frame_done, "finished frame while result still waiting")

endmodule

`default_nettype wire
